// ----- hdl/int32_to_decimal_ascii_defines.svh -----
`ifndef INT32_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT32_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define I2A_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define I2A_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2a_pkg.sv -----
`default_nettype none

package i2a_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    // double-dabble bit steps folded into one pipeline stage
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    // decimal digits needed for a bits-wide unsigned value (1233/4096 ~ log10(2))
    function automatic int num_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/i2a_dabble_stage.sv -----
`default_nettype none

module i2a_dabble_stage #(
    parameter int ND    = 10,
    parameter int MAG_W = 32,
    parameter int STEPS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_neg,
    input  wire logic [MAG_W-1:0]  in_mag,
    input  wire logic [ND*4-1:0]   in_bcd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_neg,
    output logic [MAG_W-1:0]       out_mag,
    output logic [ND*4-1:0]        out_bcd
);
    import i2a_pkg::*;

    localparam int BCD_W = ND * 4;

    logic             valid_reg;
    logic             neg_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [MAG_W-1:0] mag_next;
    logic [BCD_W-1:0] bcd_next;

    // STEPS rounds of add-3 then shift, top magnitude bit shifted in
    always_comb
    begin
        bcd_next = in_bcd;
        mag_next = in_mag;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < ND; d++)
            begin
                if (bcd_next[d*4 +: 4] >= BCD_ADJ_MIN)
                begin
                    bcd_next[d*4 +: 4] = bcd_next[d*4 +: 4] + BCD_ADJ;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], mag_next[MAG_W-1]};
            mag_next = {mag_next[MAG_W-2:0], 1'b0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            neg_reg <= in_neg;
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;
    assign out_bcd   = bcd_reg;

endmodule

`default_nettype wire

// ----- hdl/i2a_serializer.sv -----
`default_nettype none

module i2a_serializer #(
    parameter int ND    = 10,
    parameter int IDX_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load_valid,
    output logic                      load_ready,
    input  wire logic                 load_neg,
    input  wire logic [ND-1:0][3:0]   load_bcd,
    output logic                      char_valid,
    input  wire logic                 char_ready,
    output logic [7:0]                char_code,
    output logic                      last_char
);
    import i2a_pkg::*;

    logic               busy_reg;
    logic               sign_pend_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ND-1:0][3:0] dig_reg;
    logic [IDX_W-1:0]   msd_idx;

    // most significant nonzero digit; zero keeps index 0 and prints "0"
    always_comb
    begin
        msd_idx = '0;
        for (int d = 0; d < ND; d++)
        begin
            if (load_bcd[d] != 4'd0)
            begin
                msd_idx = IDX_W'(d);
            end
        end
    end

    assign char_valid = busy_reg;
    assign last_char  = busy_reg && !sign_pend_reg && (idx_reg == '0);
    assign char_code  = sign_pend_reg ? CHAR_MINUS : (CHAR_ZERO | {4'd0, dig_reg[idx_reg]});
    // next item loads while the final character of this one is taken
    assign load_ready = !busy_reg || (char_ready && last_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sign_pend_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load_valid && load_ready)
        begin
            busy_reg      <= 1'b1;
            sign_pend_reg <= load_neg;
            idx_reg       <= msd_idx;
        end
        else if (char_valid && char_ready)
        begin
            priority if (sign_pend_reg)
            begin
                sign_pend_reg <= 1'b0;
            end
            else if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            dig_reg <= load_bcd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/int32_to_decimal_ascii.sv -----
// Channel  Handshake                 Item fields
// -------  ------------------------  ----------------------------------
// input    value_valid / value_ready value (signed, VALUE_BITS)
// output   char_valid / char_ready   char_code (8), last_char (1)
//
// Path: one input register, then ceil(VALUE_BITS/4) double-dabble stages,
// then the character serializer register that drives the first character.
// Rate: one character per cycle while char_ready is high; an item's text has
// 1 to 11 characters at 32 bits.
// Reset (rst_n, async low) clears all valid and control state; no sweep.
// A stall on char_ready backs up through the stages; nothing is dropped.
`default_nettype none

`include "int32_to_decimal_ascii_defines.svh"

module int32_to_decimal_ascii #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         value_valid,
    output logic                              value_ready,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output logic                              char_valid,
    input  wire logic                         char_ready,
    output logic [7:0]                        char_code,
    output logic                              last_char
);
    import i2a_pkg::*;

    localparam int ND     = num_digits(VALUE_BITS);
    localparam int STEPS  = STEPS_PER_STAGE;
    localparam int STAGES = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int MAG_W  = STAGES * STEPS;
    localparam int IDX_W  = $clog2(ND);

    logic                  vld [0:STAGES];
    logic                  rdy [0:STAGES];
    logic                  neg [0:STAGES];
    logic [MAG_W-1:0]      mag [0:STAGES];
    logic [ND*4-1:0]       bcd [0:STAGES];

    logic                  in_valid_reg;
    logic                  in_neg_reg;
    logic [MAG_W-1:0]      in_mag_reg;
    logic [VALUE_BITS-1:0] abs_val;

    logic                  char_fire;
    logic                  char_is_minus;
    logic                  char_is_digit;

    // unsigned magnitude: the most negative value maps to 2^(VALUE_BITS-1)
    assign abs_val = value[VALUE_BITS-1]
                   ? (VALUE_BITS'(~value) + VALUE_BITS'(1))
                   : VALUE_BITS'(value);

    assign value_ready = !in_valid_reg || rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (value_ready)
        begin
            in_valid_reg <= value_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_ready && value_valid)
        begin
            in_neg_reg <= value[VALUE_BITS-1];
            in_mag_reg <= MAG_W'(abs_val);
        end
    end

    assign vld[0] = in_valid_reg;
    assign neg[0] = in_neg_reg;
    assign mag[0] = in_mag_reg;
    assign bcd[0] = '0;

    for (genvar i = 1; i <= STAGES; i++)
    begin : g_stage
        i2a_dabble_stage #(
            .ND    (ND),
            .MAG_W (MAG_W),
            .STEPS (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i-1]),
            .in_ready  (rdy[i-1]),
            .in_neg    (neg[i-1]),
            .in_mag    (mag[i-1]),
            .in_bcd    (bcd[i-1]),
            .out_valid (vld[i]),
            .out_ready (rdy[i]),
            .out_neg   (neg[i]),
            .out_mag   (mag[i]),
            .out_bcd   (bcd[i])
        );
    end

    i2a_serializer #(
        .ND    (ND),
        .IDX_W (IDX_W)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (vld[STAGES]),
        .load_ready (rdy[STAGES]),
        .load_neg   (neg[STAGES]),
        .load_bcd   (bcd[STAGES]),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    assign char_fire     = char_valid && char_ready;
    assign char_is_minus = (char_code == CHAR_MINUS);
    assign char_is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

    // every magnitude bit has been shifted into the BCD word by the last stage
    `I2A_ASSERT_IMP(a_mag_drained, vld[STAGES], mag[STAGES] == '0, "magnitude left over")
    `I2A_ASSERT_IMP(a_char_legal, char_valid, char_is_minus || char_is_digit, "bad character code")
    `I2A_ASSERT_IMP(a_minus_not_last, char_valid && char_is_minus, !last_char, "minus flagged last")
    `I2A_ASSERT_NXT(a_text_continues, char_fire && !last_char, char_valid, "text stopped early")

endmodule

`default_nettype wire
